### rtl/lfkis_pkg.sv
package lfkis_pkg;
  localparam int MaxParticlesDef = 64;
  localparam int KeyWidthDef = 32;
  localparam int IndexWidth = 6;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_EMIT = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic insert;
    logic emit_start;
    logic emit_step;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic emit_last;
  } dp_stat_t;
endpackage

### rtl/lfkis_ctrl.sv
module lfkis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last_particle,
  input  lfkis_pkg::dp_stat_t stat,
  output lfkis_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);
  import lfkis_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign busy = (state_r != ST_LOAD);
  assign take = start && !busy;
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    cmd.insert = take && !stat.full;
    cmd.emit_start = take && in_last_particle;
    cmd.emit_step = (state_r == ST_EMIT);
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (take && in_last_particle) state_nxt = ST_EMIT;
      ST_EMIT: if (stat.emit_last) state_nxt = ST_LOAD;
      ST_DONE: state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end
endmodule

### rtl/lfkis_chain.sv
module lfkis_chain #(
  parameter int MAX_PARTICLES = lfkis_pkg::MaxParticlesDef,
  parameter int KEY_WIDTH = lfkis_pkg::KeyWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lfkis_pkg::dp_cmd_t           cmd,
  input  logic [KEY_WIDTH-1:0]         kx,
  input  logic [KEY_WIDTH-1:0]         ky,
  input  logic [KEY_WIDTH-1:0]         kz,
  input  logic [KEY_WIDTH-1:0]         kv,
  output lfkis_pkg::dp_stat_t          stat,
  output logic [lfkis_pkg::IndexWidth-1:0] idx_out,
  output logic                         last_out
);
  import lfkis_pkg::*;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int TW = 4 * KEY_WIDTH;

  logic [TW-1:0]         key_r [MAX_PARTICLES];
  logic [IndexWidth-1:0] idx_r [MAX_PARTICLES];
  logic [CW-1:0]         count_r, rem_r;
  logic [TW-1:0]         nk;
  logic [MAX_PARTICLES-1:0] gt;
  logic [MAX_PARTICLES-1:0] put;
  logic [KEY_WIDTH-1:0]  sb;

  assign sb = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  assign nk = {kx ^ sb, ky ^ sb, kz ^ sb, kv ^ sb};
  assign stat.full = (count_r == CW'(MAX_PARTICLES));
  assign stat.emit_last = (rem_r == CW'(1));
  assign idx_out = idx_r[0];
  assign last_out = stat.emit_last;

  always_comb begin
    for (int i = 0; i < MAX_PARTICLES; i++)
      gt[i] = (CW'(i) < count_r) && (key_r[i] > nk);
  end

  // slot that takes the new particle: first larger entry, else the fill count
  always_comb begin
    put[0] = gt[0] || (count_r == '0);
    for (int i = 1; i < MAX_PARTICLES; i++)
      put[i] = !gt[i-1] && (gt[i] || (CW'(i) == count_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      for (int i = 0; i < MAX_PARTICLES - 1; i++) begin
        key_r[i] <= key_r[i+1];
        idx_r[i] <= idx_r[i+1];
      end
    end else if (cmd.insert) begin
      for (int i = 0; i < MAX_PARTICLES - 1; i++) begin
        if (gt[i]) begin
          key_r[i+1] <= key_r[i];
          idx_r[i+1] <= idx_r[i];
        end
      end
      for (int i = 0; i < MAX_PARTICLES; i++) begin
        if (put[i]) begin
          key_r[i] <= nk;
          idx_r[i] <= IndexWidth'(count_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rem_r <= '0;
    end else if (cmd.emit_step) begin
      rem_r <= rem_r - CW'(1);
    end else if (cmd.emit_start) begin
      rem_r <= count_r + CW'(cmd.insert);
      count_r <= '0;
    end else if (cmd.insert) begin
      count_r <= count_r + CW'(1);
    end
  end
endmodule

### rtl/lexicographic_four_key_index_sort.sv
// channel  | ports                                          | handshake
// input    | in_key_x/y/z/vx, in_last_particle              | start & !busy
// result   | out_particle_index, out_last_result            | out_valid strobe
// a particle is inserted by a parallel compare-and-shift chain
// after the last particle, one index per cycle for each held particle; busy stays high
// reset clears the fill count and returns to loading
// the receiver cannot stall; results are shown for one cycle each
module lexicographic_four_key_index_sort #(
  parameter int MAX_PARTICLES = lfkis_pkg::MaxParticlesDef,
  parameter int KEY_WIDTH = lfkis_pkg::KeyWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_key_x,
  input  logic signed [31:0] in_key_y,
  input  logic signed [31:0] in_key_z,
  input  logic signed [31:0] in_key_vx,
  input  logic        in_last_particle,
  output logic        out_valid,
  output logic [5:0]  out_particle_index,
  output logic        out_last_result
);
  import lfkis_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lfkis_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_last_particle, .stat, .cmd, .busy, .out_valid
  );

  lfkis_chain #(.MAX_PARTICLES(MAX_PARTICLES), .KEY_WIDTH(KEY_WIDTH)) u_chain (
    .clk, .rst_n, .cmd,
    .kx(KEY_WIDTH'(in_key_x)), .ky(KEY_WIDTH'(in_key_y)),
    .kz(KEY_WIDTH'(in_key_z)), .kv(KEY_WIDTH'(in_key_vx)),
    .stat, .idx_out(out_particle_index), .last_out(out_last_result)
  );

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid) else $error("emit overran");
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("not busy while emitting");
endmodule

### tb/tb_lexicographic_four_key_index_sort.sv
module tb_lexicographic_four_key_index_sort;
  import lfkis_pkg::*;

  localparam int Cap = MaxParticlesDef;

  typedef struct packed {
    logic signed [31:0] kx;
    logic signed [31:0] ky;
    logic signed [31:0] kz;
    logic signed [31:0] kvx;
    logic last;
  } particle_t;

  typedef struct packed {
    logic [5:0] idx;
    logic last;
  } sorted_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_key_x, in_key_y, in_key_z, in_key_vx;
  logic in_last_particle;
  logic out_valid;
  logic [5:0] out_particle_index;
  logic out_last_result;

  lexicographic_four_key_index_sort uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_key_x(in_key_x), .in_key_y(in_key_y), .in_key_z(in_key_z),
    .in_key_vx(in_key_vx), .in_last_particle(in_last_particle),
    .out_valid(out_valid), .out_particle_index(out_particle_index),
    .out_last_result(out_last_result)
  );

  particle_t pending_q[$];
  sorted_t order_q[$];
  logic [127:0] chain_keys[Cap];
  logic [5:0] chain_idx[Cap];
  int held;
  int errors;
  bit idle_ok;
  bit hold_send;
  int sent;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [127:0] sort_key(particle_t p);
    return {p.kx ^ 32'h8000_0000, p.ky ^ 32'h8000_0000,
            p.kz ^ 32'h8000_0000, p.kvx ^ 32'h8000_0000};
  endfunction

  task automatic insert_particle(particle_t p);
    logic [127:0] k;
    int pos;
    k = sort_key(p);
    if (held < Cap) begin
      pos = held;
      while (pos > 0 && chain_keys[pos-1] > k) begin
        chain_keys[pos] = chain_keys[pos-1];
        chain_idx[pos] = chain_idx[pos-1];
        pos--;
      end
      chain_keys[pos] = k;
      chain_idx[pos] = held[5:0];
      held++;
    end
    if (p.last) begin
      for (int i = 0; i < held; i++)
        order_q.push_back('{idx: chain_idx[i], last: (i == held - 1)});
      held = 0;
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      insert_particle({in_key_x, in_key_y, in_key_z, in_key_vx, in_last_particle});
      void'(pending_q.pop_front());
      sent++;
    end
    if (!rst_n) begin
      start <= 0;
    end else if (pending_q.size() > 0 && !hold_send &&
                 (idle_ok ? 1 : $urandom_range(99) >= 27)) begin
      particle_t p;
      p = pending_q[0];
      start <= 1;
      in_key_x <= p.kx;
      in_key_y <= p.ky;
      in_key_z <= p.kz;
      in_key_vx <= p.kvx;
      in_last_particle <= p.last;
    end else if (start && !busy) begin
      start <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (order_q.size() == 0) begin
        report("unexpected index", out_particle_index, -1);
      end else begin
        sorted_t e;
        e = order_q.pop_front();
        if (out_particle_index !== e.idx) report("particle_index", out_particle_index, e.idx);
        if (out_last_result !== e.last) report("last_result", out_last_result, e.last);
      end
    end
  end

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(3)) - 32'd1);
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic add_set(int n, bit dup, bit tight);
    particle_t p;
    logic signed [31:0] base;
    base = pick_key();
    for (int i = 0; i < n; i++) begin
      p.kx = tight ? base : pick_key();
      p.ky = tight ? $signed(32'($urandom_range(2))) : pick_key();
      p.kz = tight ? $signed(32'($urandom_range(1))) : pick_key();
      p.kvx = tight ? $signed(32'($urandom_range(2)) - 32'd1) : pick_key();
      if (dup && i > 0 && $urandom_range(2) == 0) p = pending_q[$];
      p.last = (i == n - 1);
      pending_q.push_back(p);
    end
  endtask

  initial begin
    particle_t p;
    rst_n = 0;
    start = 0;
    in_key_x = 0;
    in_key_y = 0;
    in_key_z = 0;
    in_key_vx = 0;
    in_last_particle = 0;
    held = 0;
    errors = 0;
    sent = 0;
    idle_ok = 0;
    hold_send = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // directed: single particle, extremes, ties on each key, all equal
    pending_q.push_back('{32'sh7fff_ffff, 0, 0, 0, 1'b1});
    pending_q.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0});
    pending_q.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0});
    pending_q.push_back('{0, 32'sh8000_0000, 5, 5, 1'b0});
    pending_q.push_back('{0, 32'sh8000_0000, 5, -1, 1'b0});
    pending_q.push_back('{0, 32'sh8000_0000, -5, 7, 1'b0});
    pending_q.push_back('{0, 3, 0, 0, 1'b0});
    pending_q.push_back('{0, 3, 0, 0, 1'b0});
    pending_q.push_back('{-1, 3, 0, 0, 1'b0});
    pending_q.push_back('{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0});
    pending_q.push_back('{32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b1});
    while (pending_q.size() > 0) @(posedge clk);
    wait (order_q.size() == 0);
    repeat (4) @(posedge clk);
    // overflow: 70 particles, last flag on an ignored one, no idling
    idle_ok = 1;
    add_set(70, 1, 1);
    while (pending_q.size() > 0) @(posedge clk);
    idle_ok = 0;
    hold_send = 1;
    wait (order_q.size() == 0);
    @(posedge clk);
    hold_send = 0;
    while (sent < 260) begin
      case ($urandom_range(5))
        0: add_set($urandom_range(1, 4), 0, 0);
        1: add_set($urandom_range(1, 20), 1, 1);
        2: add_set($urandom_range(5, 30), 1, 0);
        3: add_set($urandom_range(60, 66), 1, $urandom_range(1));
        default: add_set($urandom_range(2, 12), 1, 1);
      endcase
      idle_ok = ($urandom_range(4) == 0);
      while (pending_q.size() > 0) @(posedge clk);
    end
    wait (order_q.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("[lexicographic_four_key_index_sort] OK");
    else $display("[lexicographic_four_key_index_sort] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[lexicographic_four_key_index_sort] ERROR");
    $finish;
  end
endmodule

### lexicographic_four_key_index_sort.f
rtl/lfkis_pkg.sv
rtl/lfkis_ctrl.sv
rtl/lfkis_chain.sv
rtl/lexicographic_four_key_index_sort.sv
tb/tb_lexicographic_four_key_index_sort.sv
